// ----- sv/tft_window_write_parser_defines.svh -----
// Assertion macros shared by the window-write parser.
`ifndef TFT_WINDOW_WRITE_PARSER_DEFINES_SVH
`define TFT_WINDOW_WRITE_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TFTW_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TFTW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tftw_pkg.sv -----
package tftw_pkg;

	// Default frame size.
	localparam int FRAME_COLS_DEF = 320;
	localparam int FRAME_ROWS_DEF = 240;

	// Field and state widths.
	localparam int WORD_W      = 16;
	localparam int BYTE_W      = 8;
	localparam int COL_W       = 9;
	localparam int ROW_W       = 8;
	localparam int BOUND_W     = 16;
	localparam int ADDR_W      = 17;
	localparam int PIX_W       = 16;
	localparam int OUT_TDATA_W = 40;

	// Command words: the command byte spread onto the even bit positions.
	localparam logic [WORD_W-1:0] CMD_COL_SET   = 16'h0444;
	localparam logic [WORD_W-1:0] CMD_PAGE_SET  = 16'h0445;
	localparam logic [WORD_W-1:0] CMD_MEM_WRITE = 16'h0450;

	// Bit of the raw word that is low for a command.
	localparam int DATA_FLAG_BIT = 1;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_COLS  = 2'd1,
		MODE_ROWS  = 2'd2,
		MODE_WRITE = 2'd3
	} parse_mode_t;

	// Clamped inclusive window.
	typedef struct packed {
		logic [COL_W-1:0] c0;
		logic [COL_W-1:0] c1;
		logic [ROW_W-1:0] r0;
		logic [ROW_W-1:0] r1;
	} win_t;

	// Parser to cursor unit: open a window, step past one pixel.
	typedef struct packed {
		logic             open;
		logic             step;
		logic [PIX_W-1:0] value;
	} pix_ctl_t;

	// Cursor position.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} cursor_t;

endpackage

// ----- sv/tftw_parser.sv -----
module tftw_parser #(
	parameter int FRAME_COLS = tftw_pkg::FRAME_COLS_DEF,
	parameter int FRAME_ROWS = tftw_pkg::FRAME_ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [tftw_pkg::WORD_W-1:0]    word,
	output tftw_pkg::pix_ctl_t             ctl,
	output tftw_pkg::win_t                 win
);
	import tftw_pkg::*;

	localparam logic [BOUND_W-1:0] COL_MAX = BOUND_W'(FRAME_COLS - 1);
	localparam logic [BOUND_W-1:0] ROW_MAX = BOUND_W'(FRAME_ROWS - 1);

	parse_mode_t         mode_q, mode_d;
	logic [1:0]          pidx_q;
	logic [BOUND_W-1:0]  col_b_q [2];
	logic [BOUND_W-1:0]  row_b_q [2];
	win_t                win_q;
	logic [BYTE_W-1:0]   pend_q;
	logic                have_q;

	logic                is_cmd;
	logic [BYTE_W-1:0]   data_byte;
	logic                load_bound;
	logic                load_high;
	logic                open_win;
	logic                emit;
	logic [BOUND_W-1:0]  c0, c1, r0, r1, c1_lo, r1_lo;

	// Command flag from bit DATA_FLAG_BIT; data byte gathered from the even bit positions.
	always_comb begin
		is_cmd = !word[DATA_FLAG_BIT];
		for (int k = 0; k < BYTE_W; k++) begin
			data_byte[k] = word[2*k];
		end
	end

	// Clamp the received bounds to the frame.
	always_comb begin
		c0    = (col_b_q[0] > COL_MAX) ? COL_MAX : col_b_q[0];
		c1_lo = (col_b_q[1] < c0) ? c0 : col_b_q[1];
		c1    = (c1_lo > COL_MAX) ? COL_MAX : c1_lo;
		r0    = (row_b_q[0] > ROW_MAX) ? ROW_MAX : row_b_q[0];
		r1_lo = (row_b_q[1] < r0) ? r0 : row_b_q[1];
		r1    = (r1_lo > ROW_MAX) ? ROW_MAX : r1_lo;
	end

	// Next parse mode.
	always_comb begin
		mode_d = mode_q;
		if (go) begin
			if (is_cmd) begin
				case (word)
					CMD_COL_SET:   mode_d = MODE_COLS;
					CMD_PAGE_SET:  mode_d = MODE_ROWS;
					CMD_MEM_WRITE: mode_d = MODE_WRITE;
					default:       mode_d = MODE_IDLE;
				endcase
			end else if ((mode_q == MODE_COLS || mode_q == MODE_ROWS) && pidx_q == 2'd3) begin
				mode_d = MODE_IDLE;
			end
		end
	end

	// Actions taken for the current request.
	always_comb begin
		load_bound = 1'b0;
		load_high  = 1'b0;
		open_win   = 1'b0;
		emit       = 1'b0;
		if (go) begin
			if (is_cmd) begin
				open_win = (word == CMD_MEM_WRITE);
			end else begin
				case (mode_q)
					MODE_COLS, MODE_ROWS: load_bound = 1'b1;
					MODE_WRITE: begin
						load_high = !have_q;
						emit      = have_q;
					end
					default: ;
				endcase
			end
		end
	end

	// Parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			pidx_q     <= '0;
			col_b_q[0] <= '0;
			col_b_q[1] <= '0;
			row_b_q[0] <= '0;
			row_b_q[1] <= '0;
			win_q      <= '0;
			have_q     <= 1'b0;
		end else begin
			mode_q <= mode_d;
			if (go && is_cmd) begin
				pidx_q <= '0;
				have_q <= 1'b0;
			end
			if (load_bound) begin
				pidx_q <= pidx_q + 2'd1;
				if (mode_q == MODE_COLS) begin
					if (!pidx_q[0]) begin
						col_b_q[pidx_q[1]][BOUND_W-1:BYTE_W] <= data_byte;
					end else begin
						col_b_q[pidx_q[1]][BYTE_W-1:0] <= data_byte;
					end
				end else begin
					if (!pidx_q[0]) begin
						row_b_q[pidx_q[1]][BOUND_W-1:BYTE_W] <= data_byte;
					end else begin
						row_b_q[pidx_q[1]][BYTE_W-1:0] <= data_byte;
					end
				end
			end
			if (open_win) begin
				win_q.c0 <= c0[COL_W-1:0];
				win_q.c1 <= c1[COL_W-1:0];
				win_q.r0 <= r0[ROW_W-1:0];
				win_q.r1 <= r1[ROW_W-1:0];
			end
			if (load_high) begin
				have_q <= 1'b1;
			end else if (emit) begin
				have_q <= 1'b0;
			end
		end
	end

	// Buffered high pixel byte.
	always_ff @(posedge clk) begin
		if (load_high) begin
			pend_q <= data_byte;
		end
	end

	// Window being opened is taken straight from the clamp so the cursor loads it.
	always_comb begin
		ctl.open  = open_win;
		ctl.step  = emit;
		ctl.value = {pend_q, data_byte};
		if (open_win) begin
			win.c0 = c0[COL_W-1:0];
			win.c1 = c1[COL_W-1:0];
			win.r0 = r0[ROW_W-1:0];
			win.r1 = r1[ROW_W-1:0];
		end else begin
			win = win_q;
		end
	end

endmodule

// ----- sv/tftw_cursor.sv -----
module tftw_cursor #(
	parameter int FRAME_COLS = tftw_pkg::FRAME_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tftw_pkg::pix_ctl_t            ctl,
	input  tftw_pkg::win_t                win,
	output tftw_pkg::cursor_t             cur,
	output logic [tftw_pkg::ADDR_W-1:0]   addr
);
	import tftw_pkg::*;

	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(FRAME_COLS);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Raster walk over the window, wrapping back to its start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.open) begin
			col_q <= win.c0;
			row_q <= win.r0;
		end else if (ctl.step) begin
			if (col_q >= win.c1) begin
				col_q <= win.c0;
				row_q <= (row_q >= win.r1) ? win.r0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Frame buffer index of the current pixel.
	always_comb begin
		addr    = ADDR_W'(col_q) + ADDR_W'(row_q) * ROW_STRIDE;
		cur.col = col_q;
		cur.row = row_q;
	end

endmodule

// ----- sv/tft_window_write_parser.sv -----
// Display-controller window-write parser. Each request on the s_ side is one raw
// sampled SPI word; column-set and page-set commands load the window bounds,
// memory-write opens the window clamped to the frame, and every following pair
// of data words yields one pixel request on the m_ side with its frame buffer
// address (x + y * FRAME_COLS). The block takes one word per clock when the
// output is not stalled; a word passes an input register and its pixel is
// registered in the output register. The per-word path is the bound clamp
// feeding the cursor and the cursor-times-width address product.
// Back-pressure on m_tready holds the output register and then the input register.
module tft_window_write_parser #(
	parameter int FRAME_COLS = tftw_pkg::FRAME_COLS_DEF,
	parameter int FRAME_ROWS = tftw_pkg::FRAME_ROWS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [tftw_pkg::WORD_W-1:0]        s_tdata,  // [15:0] raw_word
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tftw_pkg::OUT_TDATA_W-1:0]   m_tdata   // [16:0] pixel_address,
	                                                     // [32:17] pixel_value
);
	import tftw_pkg::*;

	`include "tft_window_write_parser_defines.svh"

	localparam logic [ADDR_W-1:0] FRAME_PIXELS = ADDR_W'(FRAME_COLS * FRAME_ROWS);

	logic [WORD_W-1:0]      word_s1;
	logic                   valid_s1;
	logic                   advance;
	logic                   go;
	pix_ctl_t               ctl;
	win_t                   win;
	cursor_t                cur;
	logic [ADDR_W-1:0]      addr;
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// Handshake: the word in the input register is worked when the output can take it.
	always_comb begin
		advance  = !m_valid_q || m_tready;
		go       = valid_s1 && advance;
		s_tready = !valid_s1 || advance;
		m_tvalid = m_valid_q;
		m_tdata  = m_data_q;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= s_tdata;
		end
	end

	tftw_parser #(
		.FRAME_COLS (FRAME_COLS),
		.FRAME_ROWS (FRAME_ROWS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.word   (word_s1),
		.ctl    (ctl),
		.win    (win)
	);

	tftw_cursor #(
		.FRAME_COLS (FRAME_COLS)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.win    (win),
		.cur    (cur),
		.addr   (addr)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= ctl.step;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl.step) begin
			m_data_q <= OUT_TDATA_W'({ctl.value, addr});
		end
	end

	// Checks.
	`TFTW_ASSERT_IMPLIES(a_step_needs_go, clk, arst_n, ctl.step || ctl.open, go,
		"parser acted without an accepted word")
	`TFTW_ASSERT_NEXT(a_open_loads_cursor, clk, arst_n, ctl.open,
		cur.col == win.c0 && cur.row == win.r0, "cursor not at window start after open")
	`TFTW_ASSERT_IMPLIES(a_addr_in_frame, clk, arst_n, m_valid_q,
		m_data_q[ADDR_W-1:0] < FRAME_PIXELS, "pixel address outside the frame")

endmodule
